### rtl/assert_macros.svh
// Assertion helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define UDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define UDE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ude_pkg.sv
package ude_pkg;

    localparam int YEAR_WIDTH_DEF    = 10;
    localparam int YEAR_BASE         = 1900;
    localparam int YEAR_MIN          = 70;
    localparam int MONTH_MAX         = 11;
    localparam int DAY_MAX           = 31;
    localparam int HOUR_MAX          = 24;
    localparam int MINUTE_MAX        = 60;
    localparam int SECOND_MAX        = 60;
    localparam int DAYS_PER_YEAR     = 365;
    localparam int MONTH_FEB         = 1;
    // leap_count(1969) + 1 for the day-of-month offset
    localparam int DAY_BIAS          = 478;
    // q / 25 == (q * RECIP_25) >> RECIP_SHIFT for q < 2**15
    localparam int RECIP_25          = 41944;
    localparam int RECIP_W           = 16;
    localparam int RECIP_SHIFT       = 20;
    localparam int LEAP_R25          = 24;
    localparam int LEAP_D25_MOD4     = 3;
    localparam int SEC_PER_DAY       = 86400;
    localparam int SEC_PER_DAY_W     = 17;
    localparam int SEC_PER_HOUR      = 3600;
    localparam int SEC_PER_MIN       = 60;
    localparam int TOD_W             = 17;
    localparam int SECS_W            = 35;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_CNT_W       = 2;

    typedef struct packed {
        logic       bad;
        logic [3:0] mon;
        logic [5:0] day;
        logic [4:0] hr;
        logic [5:0] mn;
        logic [5:0] sc;
    } ude_item_t;

    localparam int ITEM_W = $bits(ude_item_t);

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
    } ude_qstat_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] mon);
        logic [8:0] d;
        begin
            unique case (mon)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                4'd11:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

### rtl/ude_front.sv
module ude_front #(
    parameter int YEAR_WIDTH = ude_pkg::YEAR_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [YEAR_WIDTH-1:0] years_since_1900,
    input  logic [3:0]            month_index,
    input  logic [5:0]            day_of_month,
    input  logic [4:0]            hour_of_day,
    input  logic [5:0]            minute_of_hour,
    input  logic [5:0]            second_of_minute,
    output logic                  f_valid,
    input  logic                  f_ready,
    output logic [YEAR_WIDTH-1:0] f_year,
    output ude_pkg::ude_item_t    f_item
);

    logic                  valid_reg;
    logic [YEAR_WIDTH-1:0] year_reg;
    ude_pkg::ude_item_t    item_reg;
    ude_pkg::ude_item_t    item_next;
    logic                  range_bad;
    logic                  epoch_day0;
    logic                  load;

    assign in_ready = !valid_reg || f_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        range_bad = (years_since_1900 < YEAR_WIDTH'(ude_pkg::YEAR_MIN))
                 || (month_index > 4'(ude_pkg::MONTH_MAX))
                 || (day_of_month > 6'(ude_pkg::DAY_MAX))
                 || (hour_of_day > 5'(ude_pkg::HOUR_MAX))
                 || (minute_of_hour > 6'(ude_pkg::MINUTE_MAX))
                 || (second_of_minute > 6'(ude_pkg::SECOND_MAX));
        // day 0 of the first month would precede the epoch
        epoch_day0 = (years_since_1900 == YEAR_WIDTH'(ude_pkg::YEAR_MIN))
                  && (month_index == 4'd0) && (day_of_month == 6'd0);
        item_next.bad = range_bad || epoch_day0;
        item_next.mon = month_index;
        item_next.day = day_of_month;
        item_next.hr  = hour_of_day;
        item_next.mn  = minute_of_hour;
        item_next.sc  = second_of_minute;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            year_reg <= years_since_1900;
            item_reg <= item_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_year  = year_reg;
    assign f_item  = item_reg;

endmodule

### rtl/ude_queue.sv
module ude_queue #(
    parameter int DATA_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  logic [DATA_W-1:0]  wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output logic [DATA_W-1:0]  rd_data,
    output ude_pkg::ude_qstat_t stat
);

    logic [DATA_W-1:0]               entry_reg [ude_pkg::QUEUE_DEPTH];
    logic                            wr_ptr_reg;
    logic                            rd_ptr_reg;
    logic [ude_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [ude_pkg::QUEUE_CNT_W-1:0] count_next;
    logic                            push;
    logic                            pop;

    assign wr_ready = count_reg != ude_pkg::QUEUE_CNT_W'(ude_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign stat.count = count_reg;

endmodule

### rtl/ude_back.sv
module ude_back #(
    parameter int YEAR_WIDTH = ude_pkg::YEAR_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        b_valid,
    output logic                        b_ready,
    input  logic [YEAR_WIDTH-1:0]       b_year,
    input  ude_pkg::ude_item_t          b_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ude_pkg::SECS_W-1:0]  epoch_seconds,
    output logic                        invalid_flag
);

    localparam int YMAX   = ude_pkg::YEAR_BASE - 1 + 2**YEAR_WIDTH;
    localparam int QW     = $clog2(YMAX / 4 + 1);
    localparam int SW     = QW + 2;
    localparam int PRW    = QW + ude_pkg::RECIP_W;
    localparam int D25W   = QW - 4;
    localparam int DW     = $clog2((2**YEAR_WIDTH) * 366 + 1);
    localparam int PW_RAW = DW + ude_pkg::SEC_PER_DAY_W;
    localparam int PW     = (PW_RAW > ude_pkg::SECS_W) ? PW_RAW : ude_pkg::SECS_W;

    // stage 1: year quotient and reciprocal product
    logic                  s1_valid_reg;
    logic [YEAR_WIDTH-1:0] s1_year_reg;
    ude_pkg::ude_item_t    s1_item_reg;
    logic [QW-1:0]         s1_q_reg;
    logic [PRW-1:0]        s1_prod_reg;
    logic                  s1_ready;
    logic [SW-1:0]         ysum;
    logic [QW-1:0]         q_next;
    logic [PRW-1:0]        prod_next;

    // stage 2: day count and time of day
    logic                       s2_valid_reg;
    logic                       s2_bad_reg;
    logic [DW-1:0]              s2_days_reg;
    logic [ude_pkg::TOD_W-1:0]  s2_tod_reg;
    logic                       s2_ready;
    logic [D25W-1:0]            d25;
    logic [D25W-1:0]            d100;
    logic [QW-1:0]              r25_full;
    logic                       leap;
    logic                       feb_adj;
    logic [DW-1:0]              days_next;
    logic [ude_pkg::TOD_W-1:0]  tod_next;

    // stage 3: seconds, output register
    logic                       out_valid_reg;
    logic                       out_bad_reg;
    logic [ude_pkg::SECS_W-1:0] out_secs_reg;
    logic [PW-1:0]              secs_full;

    assign b_ready  = !s1_valid_reg || s1_ready;
    assign s1_ready = !s2_valid_reg || s2_ready;
    assign s2_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        ysum      = SW'(b_year) + SW'(ude_pkg::YEAR_BASE - 1);
        q_next    = ysum[SW-1:2];
        prod_next = PRW'(q_next) * PRW'(ude_pkg::RECIP_25);
    end

    always_comb
    begin
        d25      = s1_prod_reg[PRW-1:ude_pkg::RECIP_SHIFT];
        d100     = d25 >> 2;
        r25_full = s1_q_reg - QW'(QW'(d25) * QW'(25));
        // century years are leap only when divisible by 400
        leap     = (s1_year_reg[1:0] == 2'b00)
                && ((r25_full[4:0] != 5'(ude_pkg::LEAP_R25))
                    || (d25[1:0] == 2'(ude_pkg::LEAP_D25_MOD4)));
        feb_adj  = leap && (s1_item_reg.mon > 4'(ude_pkg::MONTH_FEB));
        days_next = DW'((DW'(s1_year_reg) - DW'(ude_pkg::YEAR_MIN))
                        * DW'(ude_pkg::DAYS_PER_YEAR))
                  + DW'(s1_q_reg) + DW'(d100)
                  + DW'(ude_pkg::days_before_month(s1_item_reg.mon))
                  + DW'(feb_adj) + DW'(s1_item_reg.day)
                  - DW'(d25) - DW'(ude_pkg::DAY_BIAS);
        tod_next  = ude_pkg::TOD_W'(ude_pkg::TOD_W'(s1_item_reg.hr)
                                    * ude_pkg::TOD_W'(ude_pkg::SEC_PER_HOUR))
                  + ude_pkg::TOD_W'(ude_pkg::TOD_W'(s1_item_reg.mn)
                                    * ude_pkg::TOD_W'(ude_pkg::SEC_PER_MIN))
                  + ude_pkg::TOD_W'(s1_item_reg.sc);
    end

    assign secs_full = PW'(PW'(s2_days_reg) * PW'(ude_pkg::SEC_PER_DAY)) + PW'(s2_tod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                s1_valid_reg <= b_valid;
            end
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && b_valid)
        begin
            s1_year_reg <= b_year;
            s1_item_reg <= b_item;
            s1_q_reg    <= q_next;
            s1_prod_reg <= prod_next;
        end
        if (s1_ready && s1_valid_reg)
        begin
            s2_bad_reg  <= s1_item_reg.bad;
            s2_days_reg <= days_next;
            s2_tod_reg  <= tod_next;
        end
        if (s2_ready && s2_valid_reg)
        begin
            out_bad_reg  <= s2_bad_reg;
            out_secs_reg <= s2_bad_reg ? '0 : secs_full[ude_pkg::SECS_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign epoch_seconds = out_secs_reg;
    assign invalid_flag  = out_bad_reg;

endmodule

### rtl/utc_date_to_epoch_seconds.sv
// Channel | Handshake            | Payload
// request | in_valid / in_ready  | years_since_1900, month_index, day_of_month,
//         |                      | hour_of_day, minute_of_hour, second_of_minute
// result  | out_valid / out_ready| epoch_seconds, invalid_flag
//
// One request per cycle when nothing stalls; each result is valid once its accepted request
// has passed the input register, a queue slot and three back stages.
// The back end's widest step is the days-times-86400 multiply in the last stage.
// rst_n clears all valid state asynchronously; the block is ready right after reset.
// A stalled result holds the back pipeline; the two-entry queue keeps the front accepting until full.
`include "assert_macros.svh"

module utc_date_to_epoch_seconds #(
    parameter int YEAR_WIDTH = ude_pkg::YEAR_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [YEAR_WIDTH-1:0]      years_since_1900,
    input  logic [3:0]                 month_index,
    input  logic [5:0]                 day_of_month,
    input  logic [4:0]                 hour_of_day,
    input  logic [5:0]                 minute_of_hour,
    input  logic [5:0]                 second_of_minute,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ude_pkg::SECS_W-1:0] epoch_seconds,
    output logic                       invalid_flag
);

    localparam int QDW = YEAR_WIDTH + ude_pkg::ITEM_W;

    logic                  f_valid;
    logic                  f_ready;
    logic [YEAR_WIDTH-1:0] f_year;
    ude_pkg::ude_item_t    f_item;
    logic                  b_valid;
    logic                  b_ready;
    logic [QDW-1:0]        b_data;
    ude_pkg::ude_qstat_t   q_stat;

    ude_front #(
        .YEAR_WIDTH(YEAR_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .years_since_1900 (years_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .f_valid          (f_valid),
        .f_ready          (f_ready),
        .f_year           (f_year),
        .f_item           (f_item)
    );

    ude_queue #(
        .DATA_W(QDW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_year, f_item}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data),
        .stat     (q_stat)
    );

    ude_back #(
        .YEAR_WIDTH(YEAR_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .b_valid       (b_valid),
        .b_ready       (b_ready),
        .b_year        (b_data[QDW-1:ude_pkg::ITEM_W]),
        .b_item        (b_data[ude_pkg::ITEM_W-1:0]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .epoch_seconds (epoch_seconds),
        .invalid_flag  (invalid_flag)
    );

    `UDE_ASSERT(a_invalid_zero, out_valid && invalid_flag |-> epoch_seconds == '0, "invalid result carries nonzero seconds")
    `UDE_ASSERT(a_queue_bound, q_stat.count <= ude_pkg::QUEUE_CNT_W'(ude_pkg::QUEUE_DEPTH), "queue count beyond depth")
    `UDE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "block not idle in reset")

endmodule

### dv/epoch_result_checker.sv
module epoch_result_checker #(
    parameter int YEAR_WIDTH = ude_pkg::YEAR_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [YEAR_WIDTH-1:0]      years_since_1900,
    input  logic [3:0]                 month_index,
    input  logic [5:0]                 day_of_month,
    input  logic [4:0]                 hour_of_day,
    input  logic [5:0]                 minute_of_hour,
    input  logic [5:0]                 second_of_minute,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [ude_pkg::SECS_W-1:0] epoch_seconds,
    input  logic                       invalid_flag,
    output int                         fail_count,
    output int                         pending_count,
    output int                         result_count,
    output int                         reject_count
);

    typedef struct packed {
        logic [ude_pkg::SECS_W-1:0] secs;
        logic                       bad;
    } epoch_result_t;

    localparam int unsigned MONTH_START [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    epoch_result_t expected_epochs[$];
    int            errs = 0;
    int            seen = 0;
    int            rejects = 0;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        result_count  = 0;
        reject_count  = 0;
    end

    // leap years in 1..y
    function automatic longint unsigned leaps_through(input longint unsigned y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic epoch_result_t predict_epoch(
        input longint unsigned yr,
        input longint unsigned mon,
        input longint unsigned day,
        input longint unsigned hr,
        input longint unsigned mn,
        input longint unsigned sc
    );
        epoch_result_t     r;
        longint unsigned   year;
        longint unsigned   days;
        longint unsigned   secs;
        r.secs = '0;
        r.bad  = (yr < ude_pkg::YEAR_MIN) || (mon > ude_pkg::MONTH_MAX) ||
                 (day > ude_pkg::DAY_MAX) || (hr > ude_pkg::HOUR_MAX) ||
                 (mn > ude_pkg::MINUTE_MAX) || (sc > ude_pkg::SECOND_MAX);
        // day zero of the first month of 1970 would precede the epoch
        if (yr == ude_pkg::YEAR_MIN && mon == 0 && day == 0)
        begin
            r.bad = 1'b1;
        end
        if (!r.bad)
        begin
            year = ude_pkg::YEAR_BASE + yr;
            days = (yr - ude_pkg::YEAR_MIN) * ude_pkg::DAYS_PER_YEAR + leaps_through(year - 1)
                   - leaps_through(ude_pkg::YEAR_BASE + ude_pkg::YEAR_MIN - 1);
            days = days + MONTH_START[mon];
            if (mon > ude_pkg::MONTH_FEB && year % 4 == 0 &&
                (year % 100 != 0 || year % 400 == 0))
            begin
                days = days + 1;
            end
            days = days + day - 1;
            secs = days * ude_pkg::SEC_PER_DAY + hr * ude_pkg::SEC_PER_HOUR
                   + mn * ude_pkg::SEC_PER_MIN + sc;
            r.secs = secs[ude_pkg::SECS_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        epoch_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_epochs.push_back(predict_epoch(64'(years_since_1900),
                    64'(month_index), 64'(day_of_month), 64'(hour_of_day),
                    64'(minute_of_hour), 64'(second_of_minute)));
            end
            if (out_valid && out_ready)
            begin
                seen++;
                if (invalid_flag)
                begin
                    rejects++;
                end
                if (expected_epochs.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result: expected none, actual secs=%0d bad=%0b",
                             $time, epoch_seconds, invalid_flag);
                end
                else
                begin
                    want = expected_epochs.pop_front();
                    if (epoch_seconds !== want.secs)
                    begin
                        errs++;
                        $display("%0t: epoch_seconds mismatch: expected %0d, actual %0d",
                                 $time, want.secs, epoch_seconds);
                    end
                    if (invalid_flag !== want.bad)
                    begin
                        errs++;
                        $display("%0t: invalid_flag mismatch: expected %0b, actual %0b",
                                 $time, want.bad, invalid_flag);
                    end
                end
            end
        end
        fail_count    <= errs;
        pending_count <= expected_epochs.size();
        result_count  <= seen;
        reject_count  <= rejects;
    end

endmodule

### dv/tb_top.sv
module tb_top;

    localparam int STUCK_LIMIT  = 2000;
    localparam int RANDOM_PHASE = 205;
    localparam int PHASES       = 5;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [9:0]                 years_since_1900 = '0;
    logic [3:0]                 month_index = '0;
    logic [5:0]                 day_of_month = '0;
    logic [4:0]                 hour_of_day = '0;
    logic [5:0]                 minute_of_hour = '0;
    logic [5:0]                 second_of_minute = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [ude_pkg::SECS_W-1:0] epoch_seconds;
    logic                       invalid_flag;

    int fail_count;
    int pending_count;
    int result_count;
    int reject_count;
    int stuck_cycles = 0;
    bit tx_steady = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    utc_date_to_epoch_seconds dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .years_since_1900 (years_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .epoch_seconds    (epoch_seconds),
        .invalid_flag     (invalid_flag)
    );

    epoch_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .years_since_1900 (years_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .epoch_seconds    (epoch_seconds),
        .invalid_flag     (invalid_flag),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .result_count     (result_count),
        .reject_count     (reject_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    task automatic send_date(
        input logic [9:0] yr,
        input logic [3:0] mon,
        input logic [5:0] day,
        input logic [4:0] hr,
        input logic [5:0] mn,
        input logic [5:0] sc
    );
        int gap;
        @(negedge clk);
        years_since_1900 <= yr;
        month_index      <= mon;
        day_of_month     <= day;
        hour_of_day      <= hr;
        minute_of_hour   <= mn;
        second_of_minute <= sc;
        in_valid         <= 1'b1;
        do @(posedge clk); while (!in_ready);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_date();
        int         kind;
        logic [9:0] yr;
        logic [3:0] mon;
        logic [5:0] day;
        logic [4:0] hr;
        logic [5:0] mn;
        logic [5:0] sc;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            // any bit pattern, mostly rejected
            yr  = 10'($urandom_range(0, 1023));
            mon = 4'($urandom_range(0, 15));
            day = 6'($urandom_range(0, 63));
            hr  = 5'($urandom_range(0, 31));
            mn  = 6'($urandom_range(0, 63));
            sc  = 6'($urandom_range(0, 63));
        end
        else
        begin
            if (kind < 22)
            begin
                yr = 10'(100 * $urandom_range(1, 10));
            end
            else if (kind < 26)
            begin
                yr = 10'(ude_pkg::YEAR_MIN);
            end
            else
            begin
                yr = 10'($urandom_range(ude_pkg::YEAR_MIN, 1023));
            end
            mon = 4'($urandom_range(0, ude_pkg::MONTH_MAX));
            day = 6'($urandom_range(0, ude_pkg::DAY_MAX));
            hr  = 5'($urandom_range(0, ude_pkg::HOUR_MAX));
            mn  = 6'($urandom_range(0, ude_pkg::MINUTE_MAX));
            sc  = 6'($urandom_range(0, ude_pkg::SECOND_MAX));
        end
        send_date(yr, mon, day, hr, mn, sc);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // result side: random stalls, two long holds, and steady windows
    initial
    begin : result_sink
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc == 300 || cyc == 2500)
            begin
                hold = 90;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else if ((cyc % 1500) > 1100)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                out_ready <= (hold == 0);
                if (hold > 0)
                begin
                    hold--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_date(70, 0, 1, 0, 0, 0);
        send_date(70, 0, 0, 0, 0, 0);
        send_date(70, 0, 0, 5, 0, 0);
        send_date(69, 0, 1, 0, 0, 0);
        send_date(0, 0, 0, 0, 0, 0);
        send_date(1023, 11, 31, 24, 60, 60);
        send_date(1023, 15, 63, 31, 63, 63);
        send_date(120, 12, 1, 0, 0, 0);
        send_date(120, 5, 32, 0, 0, 0);
        send_date(120, 5, 10, 25, 0, 0);
        send_date(120, 5, 10, 0, 61, 0);
        send_date(120, 5, 10, 0, 0, 61);
        send_date(120, 5, 10, 24, 60, 60);
        send_date(100, 2, 1, 0, 0, 0);
        send_date(200, 2, 1, 0, 0, 0);
        send_date(72, 1, 29, 12, 0, 0);
        send_date(70, 1, 29, 0, 0, 0);
        send_date(71, 0, 0, 0, 0, 0);
        send_date(70, 1, 0, 0, 0, 0);
        send_date(104, 2, 0, 23, 59, 59);
        send_date(138, 0, 19, 3, 14, 7);
        send_date(99, 11, 31, 23, 59, 59);
        send_date(500, 1, 31, 0, 0, 0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            tx_steady = (phase == 2);
            repeat (RANDOM_PHASE) send_random_date();
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Checked %0d conversions, %0d of them rejected inputs;", result_count,
                 reject_count);
        $display("corner dates, leap and century years, stalls and drained pauses covered.");
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
